@@ rtl/cls_pkg.sv @@
// Shared constants and types for the Cholesky linear solver.
// No dependencies; used by every module of the block.
package cls_pkg;
    localparam int MAX_N     = 64;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_N);
    localparam int SIZE_W    = IDX_W + 1;
    localparam int MADDR_W   = 2 * IDX_W;
    localparam int VADDR_W   = IDX_W + 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;

    // request codes
    localparam logic [1:0] OP_MAT   = 2'd0;
    localparam logic [1:0] OP_RHS   = 2'd1;
    localparam logic [1:0] OP_SOLVE = 2'd2;

    // regions of the vector memory
    localparam logic [1:0] VEC_RHS = 2'd0;
    localparam logic [1:0] VEC_FWD = 2'd1;
    localparam logic [1:0] VEC_SOL = 2'd2;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic data_t sat32(input logic signed [63:0] v);
        data_t r;
        if (v > SAT_MAX) r = data_t'(SAT_MAX);
        else if (v < SAT_MIN) r = data_t'(SAT_MIN);
        else r = data_t'(v);
        return r;
    endfunction
endpackage

@@ rtl/cls_div.sv @@
// Fixed-point divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// Restoring, one quotient bit per cycle. Depends on cls_pkg.
module cls_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  cls_pkg::data_t num,
    input  cls_pkg::data_t den,
    output logic          busy,
    output logic          done,
    output cls_pkg::data_t quo
);
    localparam int DW = cls_pkg::DATA_W + cls_pkg::FRAC_BITS;
    localparam int CW = $clog2(DW);

    logic [DW-1:0]                 dvd_reg;
    logic [cls_pkg::DATA_W:0]      rem_reg;
    logic [cls_pkg::DATA_W-1:0]    dvs_reg;
    logic                          neg_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [cls_pkg::DATA_W:0]      rem_sh;
    logic [cls_pkg::DATA_W:0]      rem_sub;
    logic [cls_pkg::DATA_W-1:0]    num_mag;
    logic [cls_pkg::DATA_W-1:0]    den_mag;
    logic signed [63:0]            q_s;

    assign num_mag = num[cls_pkg::DATA_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[cls_pkg::DATA_W-1] ? (~den + 1'b1) : den;
    assign rem_sh  = {rem_reg[cls_pkg::DATA_W-1:0], dvd_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num_mag, {cls_pkg::FRAC_BITS{1'b0}}};
            dvs_reg <= den_mag;
            rem_reg <= '0;
            neg_reg <= num[cls_pkg::DATA_W-1] ^ den[cls_pkg::DATA_W-1];
        end else if (busy_reg) begin
            if (!rem_sub[cls_pkg::DATA_W]) begin
                rem_reg <= rem_sub;
                dvd_reg <= {dvd_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            end
        end
    end

    // quotient magnitude held in the dividend shift register
    always_comb begin
        q_s = 64'(dvd_reg);
        if (neg_reg) q_s = -q_s;
        quo = cls_pkg::sat32(q_s);
    end

    assign busy = busy_reg;
    assign done = done_reg;
endmodule

@@ rtl/cls_sqrt.sv @@
// Integer square root floor(sqrt(a * 2^FRAC_BITS)) for positive a.
// Digit-by-digit, two radicand bits per cycle. Depends on cls_pkg.
module cls_sqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  cls_pkg::data_t a,
    output logic           done,
    output cls_pkg::data_t root
);
    localparam int SW = (cls_pkg::DATA_W + cls_pkg::FRAC_BITS + 1) / 2;
    localparam int VW = 2 * SW;
    localparam int RW = SW + 4;
    localparam int CW = $clog2(SW + 1);

    logic [VW-1:0] v_reg;
    logic [RW-1:0] rem_reg;
    logic [SW-1:0] root_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    assign rem_sh = {rem_reg[RW-3:0], v_reg[VW-1:VW-2]};
    assign trial  = RW'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(SW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= VW'({a, {cls_pkg::FRAC_BITS{1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            v_reg <= {v_reg[VW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[SW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[SW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = cls_pkg::DATA_W'(root_reg);
endmodule

@@ rtl/cholesky_linear_solver.sv @@
// Cholesky linear solver top level: load port, sequencer, matrix and vector memories.
// Depends on cls_pkg, cls_div and cls_sqrt.
//
// Usage: requests enter on s_t*. op 0 writes matrix entry (row, col), op 1 writes
// right-hand entry row, op 3 is dropped; none of them gives a result.
// op 2 starts a solve of order n = size_in_use (0 acts as 1, above 64 as 64) over
// the lower triangle: in-place factorization, forward and back substitution, then
// n results on m_t*, index 0 first, tlast on index n-1. The matrix must be reloaded
// before the next solve.
// Work per solve: roughly n^3/6 update passes, n^2/2 + 2n divider runs, n square
// roots and n^2 substitution passes; the single read port of the matrix memory and
// the bit-serial divider set how long a solve takes.
// Each result steps through OS_RD, OS_LAT and OS_WAIT, waiting in OS_WAIT for m_tready.
// s_tready is low from the solve request until the last result is taken.
// Reset: size_in_use returns to 64, the sequencer to idle; memory contents are kept
// and are undefined until written. A stalled receiver holds the result steady.
module cholesky_linear_solver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // op[1:0], row[7:2], col[13:8], value[45:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // index[5:0], solution[37:6]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);
    typedef enum logic [21:0] {
        ST_IDLE    = 22'h000001,
        ST_KK_RD   = 22'h000002,
        ST_KK_CHK  = 22'h000004,
        ST_SQRT    = 22'h000008,
        ST_COL_RD  = 22'h000010,
        ST_COL_DIV = 22'h000020,
        ST_COL_WR  = 22'h000040,
        ST_JK_RD   = 22'h000080,
        ST_JK_LAT  = 22'h000100,
        ST_PK_RD   = 22'h000200,
        ST_PK_LAT  = 22'h000400,
        ST_PJ_MUL  = 22'h000800,
        ST_PJ_SCL  = 22'h001000,
        ST_PJ_WR   = 22'h002000,
        ST_ACC_RD  = 22'h004000,
        ST_ACC_MUL = 22'h008000,
        ST_ACC_SCL = 22'h010000,
        ST_ACC_ADD = 22'h020000,
        ST_DG_RD   = 22'h040000,
        ST_DG_CHK  = 22'h080000,
        ST_DG_DIV  = 22'h100000,
        ST_OUT     = 22'h200000
    } state_t;

    typedef enum logic [2:0] {
        OS_RD   = 3'b001,
        OS_LAT  = 3'b010,
        OS_WAIT = 3'b100
    } out_state_t;

    localparam int F = cls_pkg::FRAC_BITS;

    state_t state_reg, state_next;
    state_t fact_exit, row_next;
    out_state_t ost_reg;

    logic [cls_pkg::SIZE_W-1:0] size_reg;
    cls_pkg::idx_t nm1_reg, k_reg, i_reg, j_reg, p_reg;
    logic          bwd_reg;
    cls_pkg::data_t dkk_reg, ljk_reg, pk_reg, pj_reg;
    logic signed [63:0] prod_reg, sc_reg, acc_reg;
    logic signed [63:0] sc_comb;
    logic          dkk_nz;
    logic          k_last;
    logic          row_end;
    logic signed [63:0] dg_diff;
    cls_pkg::data_t     dg_num;

    // input fields
    logic [1:0]     in_op;
    cls_pkg::idx_t  in_row, in_col;
    cls_pkg::data_t in_val;
    logic           in_acc;
    assign in_op  = s_tdata[1:0];
    assign in_row = s_tdata[7:2];
    assign in_col = s_tdata[13:8];
    assign in_val = s_tdata[45:14];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc = s_tvalid && s_tready;

    // matrix memory
    cls_pkg::data_t mat_mem [cls_pkg::MAX_N*cls_pkg::MAX_N];
    logic [cls_pkg::MADDR_W-1:0] m_raddr, m_waddr;
    logic          m_we;
    cls_pkg::data_t m_wdata, m_rdata;

    always_ff @(posedge aclk) begin
        if (m_we) mat_mem[m_waddr] <= m_wdata;
        m_rdata <= mat_mem[m_raddr];
    end

    // vector memory: right-hand, forward and solution regions
    cls_pkg::data_t vec_mem [4*cls_pkg::MAX_N];
    logic [cls_pkg::VADDR_W-1:0] v_raddr, v_waddr;
    logic          v_we;
    cls_pkg::data_t v_wdata, v_rdata;

    always_ff @(posedge aclk) begin
        if (v_we) vec_mem[v_waddr] <= v_wdata;
        v_rdata <= vec_mem[v_raddr];
    end

    assign k_last  = (k_reg == nm1_reg);
    assign dkk_nz  = (dkk_reg != '0);
    assign dg_diff = 64'(v_rdata) - acc_reg;
    assign dg_num  = cls_pkg::sat32(dg_diff);
    assign row_end = ((state_reg == ST_DG_CHK) && (m_rdata == '0)) ||
                     ((state_reg == ST_DG_DIV) && div_done);
    assign fact_exit = k_last ? ST_ACC_RD : ST_JK_RD;
    assign row_next  = (bwd_reg && i_reg == '0) ? ST_OUT : ST_ACC_RD;

    // arithmetic units
    logic           div_start, div_busy, div_done, sq_start, sq_done;
    cls_pkg::data_t div_num, div_den, div_quo, sq_root;

    cls_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .done(div_done), .quo(div_quo)
    );

    cls_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .a(m_rdata),
        .done(sq_done), .root(sq_root)
    );

    assign sq_start  = (state_reg == ST_KK_CHK) && (m_rdata > 0);
    assign div_start = (state_reg == ST_COL_DIV) ||
                       ((state_reg == ST_DG_CHK) && (m_rdata != '0));
    assign div_num   = (state_reg == ST_COL_DIV) ? m_rdata : dg_num;
    assign div_den   = (state_reg == ST_COL_DIV) ? dkk_reg : m_rdata;

    // truncating scale of a product toward zero
    assign sc_comb = (prod_reg + (prod_reg[63] ? 64'sd0 + ((64'sd1 <<< F) - 64'sd1)
                                               : 64'sd0)) >>> F;

    // read addresses
    always_comb begin
        m_raddr = {k_reg, k_reg};
        v_raddr = {cls_pkg::VEC_SOL, i_reg};
        case (state_reg)
            ST_KK_RD:  m_raddr = {k_reg, k_reg};
            ST_COL_RD: m_raddr = {i_reg, k_reg};
            ST_JK_RD:  m_raddr = {j_reg, k_reg};
            ST_PK_RD:  m_raddr = {p_reg, k_reg};
            ST_PK_LAT: m_raddr = {p_reg, j_reg};
            ST_ACC_RD: begin
                m_raddr = bwd_reg ? {j_reg, i_reg} : {i_reg, j_reg};
                v_raddr = {bwd_reg ? cls_pkg::VEC_SOL : cls_pkg::VEC_FWD, j_reg};
            end
            ST_DG_RD: begin
                m_raddr = {i_reg, i_reg};
                v_raddr = {bwd_reg ? cls_pkg::VEC_FWD : cls_pkg::VEC_RHS, i_reg};
            end
            default: ;
        endcase
    end

    // write ports
    always_comb begin
        m_we    = 1'b0;
        m_waddr = {in_row, in_col};
        m_wdata = in_val;
        v_we    = 1'b0;
        v_waddr = {cls_pkg::VEC_RHS, in_row};
        v_wdata = in_val;
        case (state_reg)
            ST_IDLE: begin
                m_we = in_acc && (in_op == cls_pkg::OP_MAT);
                v_we = in_acc && (in_op == cls_pkg::OP_RHS);
            end
            ST_SQRT: begin
                m_we    = sq_done;
                m_waddr = {k_reg, k_reg};
                m_wdata = sq_root;
            end
            ST_COL_WR: begin
                m_we    = div_done;
                m_waddr = {i_reg, k_reg};
                m_wdata = div_quo;
            end
            ST_PJ_WR: begin
                m_we    = 1'b1;
                m_waddr = {p_reg, j_reg};
                m_wdata = cls_pkg::sat32(64'(pj_reg) - sc_reg);
            end
            ST_DG_CHK: begin
                // zero diagonal: that unknown is stored as zero
                v_we    = (m_rdata == '0);
                v_waddr = {bwd_reg ? cls_pkg::VEC_SOL : cls_pkg::VEC_FWD, i_reg};
                v_wdata = '0;
            end
            ST_DG_DIV: begin
                v_we    = div_done;
                v_waddr = {bwd_reg ? cls_pkg::VEC_SOL : cls_pkg::VEC_FWD, i_reg};
                v_wdata = div_quo;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_acc && in_op == cls_pkg::OP_SOLVE) state_next = ST_KK_RD;
            ST_KK_RD:   state_next = ST_KK_CHK;
            ST_KK_CHK: begin
                if (m_rdata > 0) state_next = ST_SQRT;
                else if (m_rdata == '0 || k_last) state_next = fact_exit;
                else state_next = ST_COL_RD;
            end
            ST_SQRT: begin
                if (sq_done) state_next = (sq_root == '0 || k_last) ? fact_exit : ST_COL_RD;
            end
            ST_COL_RD:  state_next = ST_COL_DIV;
            ST_COL_DIV: state_next = ST_COL_WR;
            ST_COL_WR: begin
                if (div_done) state_next = (i_reg == nm1_reg) ? ST_JK_RD : ST_COL_RD;
            end
            ST_JK_RD:   state_next = ST_JK_LAT;
            ST_JK_LAT:  state_next = ST_PK_RD;
            ST_PK_RD:   state_next = ST_PK_LAT;
            ST_PK_LAT:  state_next = ST_PJ_MUL;
            ST_PJ_MUL:  state_next = ST_PJ_SCL;
            ST_PJ_SCL:  state_next = ST_PJ_WR;
            ST_PJ_WR: begin
                if (p_reg != nm1_reg) state_next = ST_PK_RD;
                else state_next = (j_reg == nm1_reg) ? ST_KK_RD : ST_JK_RD;
            end
            ST_ACC_RD:  state_next = (j_reg == i_reg) ? ST_DG_RD : ST_ACC_MUL;
            ST_ACC_MUL: state_next = ST_ACC_SCL;
            ST_ACC_SCL: state_next = ST_ACC_ADD;
            ST_ACC_ADD: state_next = ST_ACC_RD;
            ST_DG_RD:   state_next = ST_DG_CHK;
            ST_DG_CHK:  state_next = (m_rdata == '0) ? row_next : ST_DG_DIV;
            ST_DG_DIV:  if (div_done) state_next = row_next;
            ST_OUT: begin
                if (ost_reg == OS_WAIT && m_tready && i_reg == nm1_reg) state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer: loop counters and branch decisions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ost_reg   <= OS_RD;
            size_reg  <= cls_pkg::SIZE_W'(cls_pkg::MAX_N);
            bwd_reg   <= 1'b0;
        end else begin
            if (cfg_we) size_reg <= cfg_wdata[cls_pkg::SIZE_W-1:0];
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc && in_op == cls_pkg::OP_SOLVE) begin
                        if (size_reg == '0) nm1_reg <= '0;
                        else if (size_reg > cls_pkg::SIZE_W'(cls_pkg::MAX_N))
                            nm1_reg <= cls_pkg::IDX_W'(cls_pkg::MAX_N - 1);
                        else nm1_reg <= cls_pkg::IDX_W'(size_reg - 1'b1);
                        k_reg   <= '0;
                        bwd_reg <= 1'b0;
                    end
                end
                ST_KK_CHK: begin
                    dkk_reg <= m_rdata;
                    if (m_rdata > 0 || (m_rdata != '0 && !k_last)) begin
                        i_reg <= k_reg + 1'b1;
                    end else begin
                        // column pass skipped: set up the update loop or substitution
                        j_reg   <= k_last ? '0 : k_reg + 1'b1;
                        i_reg   <= '0;
                        acc_reg <= '0;
                    end
                end
                ST_SQRT: begin
                    if (sq_done) begin
                        dkk_reg <= sq_root;
                        if (sq_root == '0 || k_last) begin
                            j_reg   <= k_last ? '0 : k_reg + 1'b1;
                            i_reg   <= '0;
                            acc_reg <= '0;
                        end
                    end
                end
                ST_COL_WR: begin
                    if (div_done) begin
                        i_reg <= i_reg + 1'b1;
                        if (i_reg == nm1_reg) j_reg <= k_reg + 1'b1;
                    end
                end
                ST_JK_LAT: begin
                    ljk_reg <= m_rdata;
                    p_reg   <= j_reg;
                end
                ST_PK_LAT: pk_reg <= m_rdata;
                ST_PJ_MUL: begin
                    pj_reg   <= m_rdata;
                    prod_reg <= 64'(pk_reg) * 64'(ljk_reg);
                end
                ST_PJ_SCL: sc_reg <= sc_comb;
                ST_PJ_WR: begin
                    p_reg <= p_reg + 1'b1;
                    if (p_reg == nm1_reg) begin
                        if (j_reg == nm1_reg) k_reg <= k_reg + 1'b1;
                        else j_reg <= j_reg + 1'b1;
                    end
                end
                ST_ACC_MUL: prod_reg <= 64'(m_rdata) * 64'(v_rdata);
                ST_ACC_SCL: sc_reg <= sc_comb;
                ST_ACC_ADD: begin
                    acc_reg <= acc_reg + sc_reg;
                    j_reg   <= bwd_reg ? j_reg - 1'b1 : j_reg + 1'b1;
                end
                ST_DG_CHK, ST_DG_DIV: begin
                    // row of a substitution finished: move to the next row or phase
                    if (row_end) begin
                        acc_reg <= '0;
                        if (!bwd_reg) begin
                            if (i_reg == nm1_reg) begin
                                bwd_reg <= 1'b1;
                                j_reg   <= nm1_reg;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                                j_reg <= '0;
                            end
                        end else if (i_reg != '0) begin
                            i_reg <= i_reg - 1'b1;
                            j_reg <= nm1_reg;
                        end else begin
                            ost_reg <= OS_RD;
                        end
                    end
                end
                ST_OUT: begin
                    case (ost_reg)
                        OS_RD:   ost_reg <= OS_LAT;
                        OS_LAT:  ost_reg <= OS_WAIT;
                        OS_WAIT: begin
                            if (m_tready) begin
                                ost_reg <= OS_RD;
                                i_reg   <= i_reg + 1'b1;
                            end
                        end
                        default: ost_reg <= OS_RD;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // output register
    cls_pkg::data_t out_sol_reg;
    cls_pkg::idx_t  out_idx_reg;
    logic           out_last_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && ost_reg == OS_LAT) begin
            out_sol_reg  <= v_rdata;
            out_idx_reg  <= i_reg;
            out_last_reg <= (i_reg == nm1_reg);
        end
    end

    assign m_tvalid = (state_reg == ST_OUT) && (ost_reg == OS_WAIT);
    assign m_tdata  = {2'b00, out_sol_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    // checks
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("request accepted during result phase");
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5:0] == nm1_reg))
        else $error("last mark on wrong index");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_busy) else $error("divider busy while idle");
    a_div_known_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COL_DIV) |-> dkk_nz) else $error("division by zero diagonal");
endmodule

@@ verif/tb.sv @@
// Self-checking bench for cholesky_linear_solver: loads systems, solves them and
// compares every streamed solution entry against an in-bench fixed-point solver.
// Depends on cls_pkg and the RTL of the block.
module tb;
    localparam logic [1:0] OP_DROP = 2'd3;   // unknown request, dropped by the block
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE = 20;

    typedef struct {
        logic [5:0]  index;
        logic [31:0] solution;
        logic        last;
    } soln_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;

    logic [47:0] pending_reqs[$];
    soln_t       expected_solns[$];
    int          mat[64][64];
    int          rhs[64];
    int          order_reg = 64;
    int          in_gap = 0, out_gap = 0;
    bit          burst = 1'b0;
    int          mismatches = 0, solves = 0, solns_seen = 0, reqs_sent = 0;
    int          cycles = 0;

    cholesky_linear_solver DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function automatic longint qmul(input int a, input int b);
        return (longint'(a) * longint'(b)) / (longint'(1) << cls_pkg::FRAC_BITS);
    endfunction

    function automatic int qdiv(input int a, input int b);
        return clip32((longint'(a) * (longint'(1) << cls_pkg::FRAC_BITS)) / longint'(b));
    endfunction

    function automatic int qsqrt(input int a);
        longint v, r, t;
        v = longint'(a) << cls_pkg::FRAC_BITS;
        r = 0;
        for (int b = 23; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return int'(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // factor, substitute, queue n solution entries
    task automatic solve_system();
        int n;
        longint acc;
        int fwd[64];
        int sol[64];
        soln_t e;
        n = order_reg < 1 ? 1 : (order_reg > cls_pkg::MAX_N ? cls_pkg::MAX_N : order_reg);
        for (int k = 0; k < n; k++) begin
            if (mat[k][k] > 0) mat[k][k] = qsqrt(mat[k][k]);
            if (mat[k][k] != 0)
                for (int i = k + 1; i < n; i++) mat[i][k] = qdiv(mat[i][k], mat[k][k]);
            for (int j = k + 1; j < n; j++)
                for (int p = j; p < n; p++)
                    mat[p][j] = clip32(longint'(mat[p][j]) - qmul(mat[p][k], mat[j][k]));
        end
        for (int k = 0; k < n; k++)
            for (int i = k + 1; i < n; i++) mat[k][i] = mat[i][k];
        for (int i = 0; i < 64; i++) begin
            fwd[i] = 0;
            sol[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < i; j++) acc += qmul(mat[i][j], fwd[j]);
            if (mat[i][i] != 0) fwd[i] = qdiv(clip32(longint'(rhs[i]) - acc), mat[i][i]);
        end
        for (int i = n - 1; i >= 0; i--) begin
            acc = 0;
            for (int j = n - 1; j > i; j--) acc += qmul(mat[i][j], sol[j]);
            if (mat[i][i] != 0) sol[i] = qdiv(clip32(longint'(fwd[i]) - acc), mat[i][i]);
        end
        for (int i = 0; i < n; i++) begin
            e.index = i[5:0];
            e.solution = sol[i];
            e.last = (i == n - 1);
            expected_solns.push_back(e);
        end
        solves++;
    endtask

    task automatic apply_request(input logic [47:0] d);
        logic [1:0] op;
        op = d[1:0];
        case (op)
            cls_pkg::OP_MAT: mat[d[7:2]][d[13:8]] = int'(d[45:14]);
            cls_pkg::OP_RHS: rhs[d[7:2]] = int'(d[45:14]);
            cls_pkg::OP_SOLVE: solve_system();
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the request
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            s_tdata <= pending_reqs.pop_front();
            s_tvalid <= 1'b1;
            in_gap <= pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            apply_request(s_tdata);
            reqs_sent++;
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        soln_t e;
        if (aresetn && m_tvalid && m_tready) begin
            solns_seen++;
            if (expected_solns.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d val=%h last=%b",
                             m_tdata[5:0], m_tdata[37:6], m_tlast);
            end else begin
                e = expected_solns.pop_front();
                if (m_tdata[5:0] !== e.index || m_tdata[37:6] !== e.solution ||
                    m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx=%0d val=%h last=%b, got idx=%0d val=%h last=%b",
                                 e.index, e.solution, e.last,
                                 m_tdata[5:0], m_tdata[37:6], m_tlast);
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            out_gap <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic [47:0] req(input logic [1:0] op, input int r, input int c,
                                        input int v);
        return {2'b00, v[31:0], c[5:0], r[5:0], op};
    endfunction

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_solns.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_order(input int v);
        drain();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[6:0];
        order_reg = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // lower triangle and right-hand side, rows in ascending order, random content
    task automatic load_system(input int n, input bit wild);
        int v;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                if (wild) v = $urandom();
                else if (r == c) v = $urandom_range(1 << 16, 40 << 16);
                else v = $urandom_range(0, 1 << 17) - (1 << 16);
                pending_reqs.push_back(req(cls_pkg::OP_MAT, r, c, v));
            end
            v = wild ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19);
            pending_reqs.push_back(req(cls_pkg::OP_RHS, r, 0, v));
        end
    endtask

    task automatic add_noise(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 2);
            if (r == 0) pending_reqs.push_back(req(OP_DROP, $urandom_range(0, 63),
                                                   $urandom_range(0, 63), $urandom()));
            else if (r == 1) pending_reqs.push_back(req(cls_pkg::OP_MAT,
                                                        $urandom_range(0, 62),
                                                        63, $urandom()));
            else pending_reqs.push_back(req(cls_pkg::OP_RHS, $urandom_range(0, 63),
                                            $urandom_range(0, 63), $urandom()));
        end
    endtask

    initial begin
        int n;
        int rand_reqs;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // order 0 behaves as 1; extreme values
        set_order(0);
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 0, 0, 32'h7fffffff));
        pending_reqs.push_back(req(cls_pkg::OP_RHS, 0, 0, 32'h80000000));
        pending_reqs.push_back(req(OP_DROP, 63, 63, 32'hffffffff));
        pending_reqs.push_back(req(cls_pkg::OP_SOLVE, 0, 0, 0));
        // zero leading diagonal, saturating off-diagonals
        set_order(2);
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 0, 0, 0));
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 1, 0, 32'h80000000));
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 1, 1, 32'h00010000));
        pending_reqs.push_back(req(cls_pkg::OP_RHS, 0, 0, 32'h7fffffff));
        pending_reqs.push_back(req(cls_pkg::OP_RHS, 1, 0, 32'h00030000));
        pending_reqs.push_back(req(cls_pkg::OP_SOLVE, 0, 0, 0));
        // negative diagonal still divides
        set_order(3);
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 0, 0, 32'h00040000));
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 1, 0, 32'h00020000));
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 1, 1, -32'sh00050000));
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 2, 0, 32'h7fffffff));
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 2, 1, 32'h00008000));
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 2, 2, 32'h00090000));
        for (int i = 0; i < 3; i++)
            pending_reqs.push_back(req(cls_pkg::OP_RHS, i, 0, 32'h00010000));
        pending_reqs.push_back(req(cls_pkg::OP_MAT, 5, 63, 32'h12345678));
        pending_reqs.push_back(req(cls_pkg::OP_SOLVE, 63, 63, 32'hffffffff));

        // random phases: mostly small well-formed systems
        rand_reqs = 0;
        while (rand_reqs < 285) begin
            burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 8);
            set_order(n);
            repeat ($urandom_range(1, 2)) begin
                load_system(n, $urandom_range(0, 4) == 0);
                add_noise($urandom_range(0, 4));
                pending_reqs.push_back(req(cls_pkg::OP_SOLVE, $urandom_range(0, 63),
                                           $urandom_range(0, 63), $urandom()));
                rand_reqs += n * (n + 3) / 2 + 3;
            end
        end

        burst = 1'b0;
        set_order(1);
        load_system(1, 1'b0);
        pending_reqs.push_back(req(cls_pkg::OP_SOLVE, 0, 0, 0));

        drain();
        $display("%0d requests sent, %0d solves (orders 1 to 8), %0d solution entries checked",
                 reqs_sent, solves, solns_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/cls_pkg.sv
rtl/cls_div.sv
rtl/cls_sqrt.sv
rtl/cholesky_linear_solver.sv
verif/tb.sv
